// ----- hdl/lxd_pkg.sv -----
// Shared types and constants for the length/XOR packet deframer.
// Used by lxd_frame, lxd_skid and length_xor_packet_deframer_top; no dependencies.
package lxd_pkg;

    // Byte width of the received stream
    localparam int unsigned BYTE_W = 8;

    // Reset value of the maximum length register
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd64;

    // Status codes carried with each result word
    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_GOOD     = 3'd1,
        ST_BAD      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_OVERSIZE = 3'd4
    } status_t;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              last;
        status_t           status;
        logic [BYTE_W-1:0] packet_length;
    } result_t;

endpackage

// ----- hdl/length_xor_packet_deframer_top.sv -----
// A word that yields a result reaches the m_ side through the output entry, or via the skid entry if it is full.
// Throughput: one word per cycle; s_tready drops only when both output entries hold
// results not yet taken. Header words of accepted length yield no result.
// Reset: synchronous active-low aresetn; waits for a length, max_length returns to 64.
// Top level of the length/XOR packet deframer; depends on lxd_pkg, lxd_frame, lxd_skid.
module length_xor_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index, [23:16] packet_length
    output logic        m_tlast,
    output logic [2:0]  m_tuser,   // [2:0] status
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [7:0] max_length
);

    logic             in_accept;
    logic             res_valid;
    lxd_pkg::result_t res;
    lxd_pkg::result_t out_res;

    // Handshakes.
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Deframing state and result logic.
    lxd_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .rx_byte   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register and skid stage.
    lxd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // Pack the result word onto the stream ports.
    assign m_tdata = {out_res.packet_length, out_res.byte_index, out_res.data_byte};
    assign m_tlast = out_res.last;
    assign m_tuser = out_res.status;

endmodule

// ----- hdl/lxd_frame.sv -----
// Deframing state and per-word result logic, plus the max_length register.
// Depends on lxd_pkg.
module lxd_frame (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_accept,
    input  logic [lxd_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                           cfg_we,
    input  logic [lxd_pkg::BYTE_W-1:0]     cfg_data,
    output logic                           res_valid,
    output lxd_pkg::result_t               res
);

    logic [lxd_pkg::BYTE_W-1:0] max_length_reg;
    logic                       in_packet_reg, in_packet_next;
    logic [lxd_pkg::BYTE_W-1:0] expected_reg, expected_next;
    logic [lxd_pkg::BYTE_W-1:0] count_reg, count_next;
    logic [lxd_pkg::BYTE_W-1:0] xor_reg, xor_next;

    logic                       oversize;
    logic [lxd_pkg::BYTE_W-1:0] count_inc;
    logic [lxd_pkg::BYTE_W-1:0] xor_upd;
    logic                       closing;

    // Configuration register. It is checked only on header words, so a packet
    // that is already open runs to its end after a change.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= lxd_pkg::MAX_LENGTH_RESET;
        end else if (cfg_we) begin
            max_length_reg <= cfg_data;
        end
    end

    // Header check and body arithmetic. The count cannot wrap because a
    // packet closes as soon as the count reaches the length.
    assign oversize  = rx_byte > max_length_reg;
    assign count_inc = count_reg + 8'd1;
    assign xor_upd   = xor_reg ^ rx_byte;
    assign closing   = count_inc >= expected_reg;

    // Next state and result word.
    always_comb begin
        in_packet_next = in_packet_reg;
        expected_next  = expected_reg;
        count_next     = count_reg;
        xor_next       = xor_reg;
        res_valid      = 1'b0;
        res.data_byte     = rx_byte;
        res.byte_index    = count_reg;
        res.last          = 1'b0;
        res.status        = lxd_pkg::ST_BUSY;
        res.packet_length = expected_reg;

        if (!in_packet_reg) begin
            // Header word: either rejected as oversize or opens a packet.
            res.data_byte     = '0;
            res.byte_index    = '0;
            res.last          = 1'b1;
            res.status        = lxd_pkg::ST_OVERSIZE;
            res.packet_length = rx_byte;
            if (in_accept) begin
                expected_next = rx_byte;
                if (oversize) begin
                    res_valid = 1'b1;
                end else begin
                    in_packet_next = 1'b1;
                    count_next     = '0;
                    xor_next       = '0;
                end
            end
        end else begin
            // Body word: pass through, accumulate, close on the final word.
            res_valid = in_accept;
            if (closing) begin
                res.last = 1'b1;
                if (expected_reg == '0) begin
                    res.status = lxd_pkg::ST_EMPTY;
                end else if (xor_upd == '0) begin
                    res.status = lxd_pkg::ST_GOOD;
                end else begin
                    res.status = lxd_pkg::ST_BAD;
                end
            end
            if (in_accept) begin
                count_next = count_inc;
                xor_next   = xor_upd;
                if (closing) begin
                    in_packet_next = 1'b0;
                end
            end
        end
    end

    // Deframing state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0;
            expected_reg  <= '0;
            count_reg     <= '0;
            xor_reg       <= '0;
        end else begin
            in_packet_reg <= in_packet_next;
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            xor_reg       <= xor_next;
        end
    end

    // An open packet with a nonzero length never has counted all its words.
    a_count_below_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_packet_reg && expected_reg != '0) |-> (count_reg < expected_reg))
        else $error("byte count reached length inside an open packet");

    // A rejected header leaves the block waiting for a new length.
    a_oversize_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !in_packet_reg && oversize) |=> !in_packet_reg)
        else $error("oversize header opened a packet");

    // Every accepted body word yields a result word.
    a_body_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_packet_reg) |-> res_valid)
        else $error("body word produced no result");

endmodule

// ----- hdl/lxd_skid.sv -----
// Two-entry output register with skid stage for result words.
// Depends on lxd_pkg.
module lxd_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  lxd_pkg::result_t  in_data,
    output logic              in_ready,
    output logic              out_valid,
    output lxd_pkg::result_t  out_data,
    input  logic              out_ready
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    lxd_pkg::result_t out_data_reg, out_data_next;
    lxd_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_take;

    // Space is guaranteed whenever the skid entry is empty.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_take  = out_valid_reg && out_ready;

    // Entry movement.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || out_take) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags are reset; payload is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid entry only fills behind an occupied output entry.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output entry");

endmodule
